>>> hdl/fcgm_pkg.sv
// Shared types, sizes and codes for the character-to-glyph map block.
`timescale 1ns / 1ps

package fcgm_pkg;

  // Store sizes
  localparam int MAX_SEGMENTS      = 64;
  localparam int GLYPH_ARRAY_DEPTH = 1024;
  localparam int SEG_AW   = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int GLYPH_AW = $clog2(GLYPH_ARRAY_DEPTH);

  // Segment counter width: holds the configured count and the store depth
  localparam int SEG_CW = $clog2(MAX_SEGMENTS + 1);
  localparam int CNT_W  = (SEG_CW > 7) ? SEG_CW : 7;

  // Glyph array position: offset/2 + (code - start) + i - n, kept signed
  localparam int POS_W = 19;

  localparam int BYTE_CODES = 256;

  typedef enum logic [1:0] {
    CMD_LOAD_SEG   = 2'd0,
    CMD_LOAD_GLYPH = 2'd1,
    CMD_LOOKUP     = 2'd2,
    CMD_NOP        = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    FMT_BYTE    = 2'd0,
    FMT_SEGMENT = 2'd1,
    FMT_TRIMMED = 2'd2,
    FMT_RSVD    = 2'd3
  } fmt_e;

  typedef enum logic [3:0] {
    CFG_TABLE_FORMAT  = 4'd0,
    CFG_SEGMENT_COUNT = 4'd1,
    CFG_FIRST_CODE    = 4'd2,
    CFG_ENTRY_COUNT   = 4'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_CALC,
    ST_GDATA
  } state_e;

  typedef struct packed {
    logic [15:0] first;
    logic [15:0] last;
    logic [15:0] delta;
    logic [15:0] offset;
  } seg_t;

  typedef struct packed {
    logic        hit;     // start <= code <= end
    logic        direct;  // range offset is zero
    logic [15:0] sum;     // delta + code, mod 2^16
    logic [15:0] diff;    // code - start
  } match_t;

endpackage

>>> hdl/font_char_to_glyph_map.sv
// Top level: character code to glyph index map (byte, segment, trimmed formats).
`timescale 1ns / 1ps
// Loads and the unused command answer in the cycle after the transfer; byte and trimmed
//   lookups pass through dispatch and the glyph read (dispatch only for a code out of range or
//   the unknown format). The segment scan reads one segment per cycle through the shared compare
//   unit; a hit goes on to the position step and glyph read unless its range offset is zero.
// One command at a time; busy_o drops as the done_o strobe rises, which the receiver cannot
//   stall. Reset clears configuration, sequencer and result registers, not the stores.
module font_char_to_glyph_map (
  input  logic        clk_i,
  input  logic        rst_ni,
  // command channel
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  cmd_i,
  input  logic [9:0]  slot_i,
  input  logic [15:0] seg_start_i,
  input  logic [15:0] seg_end_i,
  input  logic [15:0] seg_delta_i,
  input  logic [15:0] seg_range_offset_i,
  input  logic [15:0] glyph_word_i,
  input  logic [15:0] char_code_i,
  // result
  output logic        done_o,
  output logic [15:0] glyph_index_o,
  output logic        found_o,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  import fcgm_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers, always ready; writes belong only while idle, which the block does not enforce.
  // ---------------------------------------------------------------------------
  logic [1:0]  table_format_q;
  logic [6:0]  segment_count_q;
  logic [15:0] first_code_q;
  logic [10:0] entry_count_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_format_q  <= '0;
      segment_count_q <= '0;
      first_code_q    <= '0;
      entry_count_q   <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_TABLE_FORMAT:  table_format_q  <= cfg_data_i[1:0];
        CFG_SEGMENT_COUNT: segment_count_q <= cfg_data_i[6:0];
        CFG_FIRST_CODE:    first_code_q    <= cfg_data_i;
        CFG_ENTRY_COUNT:   entry_count_q   <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  // Searched segments, clamped to the store depth
  logic [CNT_W-1:0] seg_lim;
  assign seg_lim = (CNT_W'(segment_count_q) > CNT_W'(MAX_SEGMENTS)) ?
                   CNT_W'(MAX_SEGMENTS) : CNT_W'(segment_count_q);

  // ---------------------------------------------------------------------------
  // Stores
  // ---------------------------------------------------------------------------
  logic                seg_we;
  logic [SEG_AW-1:0]   seg_addr;
  seg_t                seg_wdata;
  logic [$bits(seg_t)-1:0] seg_rdata;

  logic                g_we;
  logic [GLYPH_AW-1:0] g_addr;
  logic [15:0]         g_rdata;

  fcgm_ram #(
    .WIDTH ($bits(seg_t)),
    .DEPTH (MAX_SEGMENTS)
  ) u_seg_ram (
    .clk_i   (clk_i),
    .we_i    (seg_we),
    .addr_i  (seg_addr),
    .wdata_i (seg_wdata),
    .rdata_o (seg_rdata)
  );

  fcgm_ram #(
    .WIDTH (16),
    .DEPTH (GLYPH_ARRAY_DEPTH)
  ) u_glyph_ram (
    .clk_i   (clk_i),
    .we_i    (g_we),
    .addr_i  (g_addr),
    .wdata_i (glyph_word_i),
    .rdata_o (g_rdata)
  );

  // ---------------------------------------------------------------------------
  // Sequencer state
  // ---------------------------------------------------------------------------
  state_e state_q, state_d;

  logic [15:0]      code_q, code_d;
  logic [CNT_W-1:0] idx_q, idx_d;          // next segment to read
  logic [CNT_W-1:0] chk_idx_q, chk_idx_d;  // segment whose data is on seg_rdata
  logic             chk_vld_q, chk_vld_d;
  logic [14:0]      ro_half_q, ro_half_d;
  logic [15:0]      diff_q, diff_d;
  logic [15:0]      delta_q, delta_d;

  logic             done_q, done_d;
  logic [15:0]      glyph_q, glyph_d;
  logic             found_q, found_d;

  logic             accept;
  seg_t             seg_cur;
  match_t           match;

  assign accept  = start_i && !busy_o;
  assign busy_o  = (state_q != ST_IDLE);
  assign seg_cur = seg_t'(seg_rdata);

  fcgm_seg_unit u_seg_unit (
    .code_i  (code_q),
    .seg_i   (seg_cur),
    .match_o (match)
  );

  // Trimmed-format offset and bounds
  logic [15:0] trim_d;
  logic        trim_ok;
  assign trim_d  = code_q - first_code_q;
  assign trim_ok = (code_q >= first_code_q) &&
                   (trim_d < 16'(entry_count_q)) &&
                   (17'(trim_d) < 17'(GLYPH_ARRAY_DEPTH));

  logic byte_ok;
  assign byte_ok = (17'(code_q) < 17'(BYTE_CODES)) &&
                   (17'(code_q) < 17'(GLYPH_ARRAY_DEPTH));

  // Glyph array position for a non-direct segment hit
  logic [POS_W-1:0] pos;
  logic             pos_ok;
  assign pos    = POS_W'(ro_half_q) + POS_W'(diff_q) + POS_W'(chk_idx_q) - POS_W'(seg_lim);
  assign pos_ok = !pos[POS_W-1] && (pos < POS_W'(GLYPH_ARRAY_DEPTH));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      idx_q     <= '0;
      chk_idx_q <= '0;
      chk_vld_q <= 1'b0;
      done_q    <= 1'b0;
      glyph_q   <= '0;
      found_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      chk_idx_q <= chk_idx_d;
      chk_vld_q <= chk_vld_d;
      done_q    <= done_d;
      glyph_q   <= glyph_d;
      found_q   <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q    <= code_d;
    ro_half_q <= ro_half_d;
    diff_q    <= diff_d;
    delta_q   <= delta_d;
  end

  always_comb begin
    state_d   = state_q;
    code_d    = code_q;
    idx_d     = idx_q;
    chk_idx_d = chk_idx_q;
    chk_vld_d = 1'b0;
    ro_half_d = ro_half_q;
    diff_d    = diff_q;
    delta_d   = delta_q;
    done_d    = 1'b0;
    glyph_d   = '0;
    found_d   = 1'b0;

    seg_we    = 1'b0;
    seg_addr  = SEG_AW'(idx_q);
    seg_wdata = '{first: seg_start_i, last: seg_end_i,
                  delta: seg_delta_i, offset: seg_range_offset_i};
    g_we      = 1'b0;
    g_addr    = GLYPH_AW'(slot_i);

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd_e'(cmd_i))
            CMD_LOAD_SEG: begin
              seg_addr = SEG_AW'(slot_i);
              seg_we   = (32'(slot_i) < 32'(MAX_SEGMENTS));
              done_d   = 1'b1;
            end
            CMD_LOAD_GLYPH: begin
              g_we   = (32'(slot_i) < 32'(GLYPH_ARRAY_DEPTH));
              done_d = 1'b1;
            end
            CMD_LOOKUP: begin
              code_d  = char_code_i;
              state_d = ST_DISPATCH;
            end
            CMD_NOP: begin
              done_d = 1'b1;
            end
            default: ;
          endcase
        end
      end

      ST_DISPATCH: begin
        unique case (fmt_e'(table_format_q))
          FMT_BYTE: begin
            g_addr = GLYPH_AW'(code_q);
            if (byte_ok) begin
              state_d = ST_GDATA;
            end else begin
              done_d  = 1'b1;
              state_d = ST_IDLE;
            end
          end
          FMT_SEGMENT: begin
            idx_d   = '0;
            state_d = ST_SCAN;
          end
          FMT_TRIMMED: begin
            g_addr = GLYPH_AW'(trim_d);
            if (trim_ok) begin
              state_d = ST_GDATA;
            end else begin
              done_d  = 1'b1;
              state_d = ST_IDLE;
            end
          end
          FMT_RSVD: begin
            done_d  = 1'b1;
            state_d = ST_IDLE;
          end
          default: ;
        endcase
      end

      // One segment read per cycle; the compare checks the segment read in the cycle before.
      ST_SCAN: begin
        if (chk_vld_q && match.hit) begin
          if (match.direct) begin
            done_d  = 1'b1;
            found_d = 1'b1;
            glyph_d = match.sum;
            state_d = ST_IDLE;
          end else begin
            ro_half_d = seg_cur.offset[15:1];
            diff_d    = match.diff;
            delta_d   = seg_cur.delta;
            state_d   = ST_CALC;
          end
        end else if (idx_q < seg_lim) begin
          chk_vld_d = 1'b1;
          chk_idx_d = idx_q;
          idx_d     = idx_q + 1'b1;
        end else if (!chk_vld_q) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end

      // First containing segment decides; a bad position ends the search.
      ST_CALC: begin
        g_addr = GLYPH_AW'(pos);
        if (pos_ok) begin
          state_d = ST_GDATA;
        end else begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end

      ST_GDATA: begin
        done_d  = 1'b1;
        found_d = 1'b1;
        state_d = ST_IDLE;
        unique case (fmt_e'(table_format_q))
          FMT_BYTE:    glyph_d = {8'h00, g_rdata[7:0]};
          FMT_SEGMENT: glyph_d = (g_rdata != 16'd0) ? (g_rdata + delta_q) : 16'd0;
          FMT_TRIMMED: glyph_d = g_rdata;
          FMT_RSVD:    found_d = 1'b0;
          default: ;
        endcase
      end

      default: state_d = ST_IDLE;
    endcase
  end

  assign done_o        = done_q;
  assign glyph_index_o = glyph_q;
  assign found_o       = found_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_done_has_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ($past(busy_o) || $past(start_i)))
    else $error("result strobe without a command in flight");

  a_found_only_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q |-> done_q)
    else $error("found set outside a result cycle");

  a_miss_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && !found_q) |-> (glyph_q == 16'd0))
    else $error("unmapped result carries a non-zero glyph");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (idx_q <= seg_lim))
    else $error("segment scan ran past the searched count");

  a_load_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (cmd_i != CMD_LOOKUP)) |=> (done_q && !found_q && !busy_o))
    else $error("load or unused command did not answer in one cycle");

endmodule

>>> hdl/fcgm_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps

module fcgm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/fcgm_seg_unit.sv
// Shared segment compare unit: range test, direct delta sum, code offset.
`timescale 1ns / 1ps

module fcgm_seg_unit (
  input  logic [15:0]     code_i,
  input  fcgm_pkg::seg_t  seg_i,
  output fcgm_pkg::match_t match_o
);

  import fcgm_pkg::*;

  always_comb begin
    match_o.hit    = (code_i >= seg_i.first) && (code_i <= seg_i.last);
    match_o.direct = (seg_i.offset == 16'd0);
    match_o.sum    = seg_i.delta + code_i;
    match_o.diff   = code_i - seg_i.first;
  end

endmodule
